// ----- src/afs_pkg.sv -----
`default_nettype none
package afs_pkg;

	localparam int WORD_W     = 24;
	localparam int BYTE_W     = 8;
	localparam int CHANNELS   = 4;
	localparam int MV_W       = 16;
	localparam int UA_W       = 32;
	localparam int VGAIN_W    = 24;
	localparam int CGAIN_W    = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	// frame layout: six 24-bit words, three bytes each
	localparam logic [2:0] LAST_WORD     = 3'd5;
	localparam logic [1:0] LAST_WORD_BYTE = 2'd2;
	localparam logic [2:0] STATUS_WORD   = 3'd0;
	localparam logic [2:0] LAST_CH_WORD  = 3'd4;

	// register map
	localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_GAIN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERCURRENT_LIMIT = 2'd2;

	// defaults for the top-level parameters
	localparam int DEF_BUCK_CHANNEL       = 0;
	localparam int DEF_LDO_CHANNEL        = 1;
	localparam int DEF_CURRENT_CHANNEL    = 2;
	localparam int DEF_SENSE_CHANNEL      = 3;
	localparam int DEF_GAIN_FRACTION_BITS = 24;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic [CHANNELS-1:0][WORD_W-1:0] raw;
		logic [WORD_W-1:0]               status;
	} frame_t;

	typedef struct packed {
		logic              over_current;
		logic [UA_W-1:0]   isense_ua;
		logic [MV_W-1:0]   sense_mv;
		logic [MV_W-1:0]   ldo_mv;
		logic [MV_W-1:0]   buck_mv;
		logic [WORD_W-1:0] status_word;
	} result_t;

endpackage
`default_nettype wire

// ----- src/afs_front.sv -----
`default_nettype none
module afs_front
	import afs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic              frame_start,
	output frame_t                 push_data,
	output logic                   push
);

	logic [2:0]        word_q;
	logic [1:0]        wbyte_q;
	logic [2:0]        word;
	logic [1:0]        wbyte;
	logic [WORD_W-1:0] shift_q;
	logic [WORD_W-1:0] status_q;
	logic [WORD_W-1:0] new_word;
	logic [CHANNELS-1:0][WORD_W-1:0] raw_q;
	logic              word_done;
	logic              last;
	logic [1:0]        ch_sel;

	// frame_start restarts assembly at byte 0
	assign word      = frame_start ? 3'd0 : word_q;
	assign wbyte     = frame_start ? 2'd0 : wbyte_q;
	assign new_word  = {shift_q[WORD_W-BYTE_W-1:0], rx_byte};
	assign word_done = (wbyte == LAST_WORD_BYTE);
	assign last      = word_done && (word == LAST_WORD);
	assign ch_sel    = word[1:0] - 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q   <= '0;
			wbyte_q  <= '0;
			shift_q  <= '0;
			status_q <= '0;
		end else if (accept) begin
			shift_q <= new_word;
			if (last) begin
				word_q  <= '0;
				wbyte_q <= '0;
			end else if (word_done) begin
				word_q  <= word + 3'd1;
				wbyte_q <= '0;
			end else begin
				word_q  <= word;
				wbyte_q <= wbyte + 2'd1;
			end
			if (word_done && word == STATUS_WORD) begin
				status_q <= new_word;
			end
		end
	end

	// sample words 1..4, no reset needed
	always_ff @(posedge clk) begin
		if (accept && word_done && word != STATUS_WORD && word <= LAST_CH_WORD) begin
			raw_q[ch_sel] <= new_word;
		end
	end

	assign push             = accept && last;
	assign push_data.status = status_q;
	assign push_data.raw    = raw_q;

endmodule
`default_nettype wire

// ----- src/afs_queue.sv -----
`default_nettype none
module afs_queue
	import afs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire frame_t push_data,
	output logic        full,
	input  wire logic   pop,
	output frame_t      pop_data,
	output logic        avail
);

	frame_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign avail    = (count_q != '0);
	assign do_pop   = pop && avail;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || do_pop)
		else $error("frame queue written while full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("frame queue count out of range");

endmodule
`default_nettype wire

// ----- src/afs_back.sv -----
`default_nettype none
module afs_back
	import afs_pkg::*;
#(
	parameter int BUCK_CHANNEL       = DEF_BUCK_CHANNEL,
	parameter int LDO_CHANNEL        = DEF_LDO_CHANNEL,
	parameter int CURRENT_CHANNEL    = DEF_CURRENT_CHANNEL,
	parameter int SENSE_CHANNEL      = DEF_SENSE_CHANNEL,
	parameter int GAIN_FRACTION_BITS = DEF_GAIN_FRACTION_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [VGAIN_W-1:0] voltage_gain,
	input  wire logic [CGAIN_W-1:0] current_gain,
	input  wire logic [UA_W-1:0]    overcurrent_limit,
	input  wire logic               avail,
	input  wire frame_t             frame,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output result_t                 result
);

	localparam logic [1:0] BUCK_IDX = 2'(BUCK_CHANNEL);
	localparam logic [1:0] LDO_IDX  = 2'(LDO_CHANNEL);
	localparam logic [1:0] CUR_IDX  = 2'(CURRENT_CHANNEL);
	localparam logic [1:0] SNS_IDX  = 2'(SENSE_CHANNEL);
	localparam int OP_W = WORD_W - 1;
	localparam int VP_W = OP_W + VGAIN_W;
	localparam int CP_W = OP_W + CGAIN_W;

	logic [OP_W-1:0]   op_buck, op_ldo, op_cur, op_sns;
	logic [VP_W-1:0]   vp_buck_s1, vp_ldo_s1, vp_sns_s1;
	logic [CP_W-1:0]   cp_s1;
	logic [WORD_W-1:0] status_s1;
	logic              valid_s1;
	logic              out_free;
	logic              s1_free;
	logic [VP_W-1:0]   vq_buck, vq_ldo, vq_sns;
	logic [CP_W-1:0]   cq;
	logic [UA_W-1:0]   cur;
	result_t           result_q;
	logic              out_valid_q;

	// negative samples scale to zero: drop the operand
	function automatic logic [OP_W-1:0] mag(input logic [WORD_W-1:0] raw);
		mag = raw[WORD_W-1] ? '0 : raw[OP_W-1:0];
	endfunction

	function automatic logic [MV_W-1:0] clamp_mv(input logic [VP_W-1:0] q);
		clamp_mv = (q > VP_W'({MV_W{1'b1}})) ? {MV_W{1'b1}} : q[MV_W-1:0];
	endfunction

	assign op_buck = mag(frame.raw[BUCK_IDX]);
	assign op_ldo  = mag(frame.raw[LDO_IDX]);
	assign op_cur  = mag(frame.raw[CUR_IDX]);
	assign op_sns  = mag(frame.raw[SNS_IDX]);

	assign out_free = !out_valid_q || out_ready;
	assign s1_free  = !valid_s1 || out_free;
	assign pop      = avail && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= avail;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		if (pop) begin
			vp_buck_s1 <= op_buck * voltage_gain;
			vp_ldo_s1  <= op_ldo * voltage_gain;
			vp_sns_s1  <= op_sns * voltage_gain;
			cp_s1      <= op_cur * current_gain;
			status_s1  <= frame.status;
		end
	end

	// stage 2: drop fraction, saturate, compare
	assign vq_buck = vp_buck_s1 >> GAIN_FRACTION_BITS;
	assign vq_ldo  = vp_ldo_s1 >> GAIN_FRACTION_BITS;
	assign vq_sns  = vp_sns_s1 >> GAIN_FRACTION_BITS;
	assign cq      = cp_s1 >> GAIN_FRACTION_BITS;
	assign cur     = (cq > CP_W'({UA_W{1'b1}})) ? {UA_W{1'b1}} : cq[UA_W-1:0];

	always_ff @(posedge clk) begin
		if (valid_s1 && out_free) begin
			result_q.status_word  <= status_s1;
			result_q.buck_mv      <= clamp_mv(vq_buck);
			result_q.ldo_mv       <= clamp_mv(vq_ldo);
			result_q.sense_mv     <= clamp_mv(vq_sns);
			result_q.isense_ua    <= cur;
			result_q.over_current <= (cur > overcurrent_limit);
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_free) |=> out_valid_q)
		else $error("stage 1 result lost");

	a_oc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.over_current && result_q.isense_ua == '0))
		else $error("over-current flagged at zero current");

endmodule
`default_nettype wire

// ----- src/adc_frame_scaler.sv -----
`default_nettype none
// adc_frame_scaler: deserializes 18-byte, four-channel ADC frames (six 24-bit words, MSB
// first: status, four two's-complement samples, CRC) and gives one scaled result per frame.
// One byte is taken per cycle while s_tready is high, with no gaps needed; frame_start
// (s_tuser) restarts assembly. Each completed frame goes into a two-entry frame queue;
// a two-stage scaler (multiply, then shift/saturate/compare) drains it into the m_tvalid
// output register. s_tready drops only when two finished frames wait behind a stalled
// output. Voltages are floor(raw * voltage_gain / 2^F) clamped to 65535, current is
// floor(raw * current_gain / 2^F) clamped to 32 bits, negative samples give 0, and
// over_current is set when the current exceeds overcurrent_limit. Registers (cfg_index):
// 0 voltage_gain, 1 current_gain, 2 overcurrent_limit (reset all ones); index 3 is ignored.
// Write them only while no frame is in flight. cfg_ready is always high.
module adc_frame_scaler
	import afs_pkg::*;
#(
	parameter int BUCK_CHANNEL       = DEF_BUCK_CHANNEL,
	parameter int LDO_CHANNEL        = DEF_LDO_CHANNEL,
	parameter int CURRENT_CHANNEL    = DEF_CURRENT_CHANNEL,
	parameter int SENSE_CHANNEL      = DEF_SENSE_CHANNEL,
	parameter int GAIN_FRACTION_BITS = DEF_GAIN_FRACTION_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// byte stream in
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
	input  wire logic                  s_tuser,   // [0] frame_start
	// result out
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [23:0] status_word, [39:24] buck_mv, [55:40] ldo_mv, [71:56] sense_mv,
	// [103:72] current in microamps, [104] over_current, [111:105] zero
	output logic [111:0]               m_tdata,
	// register writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [VGAIN_W-1:0] voltage_gain_q;
	logic [CGAIN_W-1:0] current_gain_q;
	logic [UA_W-1:0]    oc_limit_q;
	logic               in_xfer;
	logic               push;
	frame_t             push_data;
	logic               q_full;
	logic               q_pop;
	logic               q_avail;
	frame_t             q_data;
	result_t            result;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign in_xfer   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voltage_gain_q <= '0;
			current_gain_q <= '0;
			oc_limit_q     <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_VOLTAGE_GAIN:      voltage_gain_q <= cfg_data[VGAIN_W-1:0];
				CFG_CURRENT_GAIN:      current_gain_q <= cfg_data[CGAIN_W-1:0];
				CFG_OVERCURRENT_LIMIT: oc_limit_q     <= cfg_data[UA_W-1:0];
				default:               ;
			endcase
		end
	end

	// front: byte assembly, one frame record per completed frame
	afs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_xfer),
		.rx_byte     (s_tdata),
		.frame_start (s_tuser),
		.push_data   (push_data),
		.push        (push)
	);

	afs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.avail     (q_avail)
	);

	// back: scaling pipeline and output register
	afs_back #(
		.BUCK_CHANNEL       (BUCK_CHANNEL),
		.LDO_CHANNEL        (LDO_CHANNEL),
		.CURRENT_CHANNEL    (CURRENT_CHANNEL),
		.SENSE_CHANNEL      (SENSE_CHANNEL),
		.GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.voltage_gain      (voltage_gain_q),
		.current_gain      (current_gain_q),
		.overcurrent_limit (oc_limit_q),
		.avail             (q_avail),
		.frame             (q_data),
		.pop               (q_pop),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.result            (result)
	);

	assign m_tdata = {7'd0, result};

endmodule
`default_nettype wire
